// ----- src/fct_pkg.sv -----
// Shared types and constants for the frustum cull test block.
package fct_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int NORM_FRAC   = 14;
  localparam int PROD_W      = 32;  // 16x16 signed product
  localparam int SUM_W       = 36;  // sums of up to 8 products
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2,
    OP_CLASS  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    POS_FRONT = 2'd0,
    POS_SPAN  = 2'd1,
    POS_BACK  = 2'd2
  } pos_t;

  typedef logic signed [15:0] s16_t;

endpackage

// ----- src/fct_if.sv -----
// Valid/ready channel interfaces for query and result words.
interface fct_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [15:0]      center_x;
  logic signed [15:0]      center_y;
  logic signed [15:0]      center_z;
  logic [14:0]             radius;
  logic [47:0]             half_axis_0;
  logic [47:0]             half_axis_1;
  logic [47:0]             half_axis_2;
  modport source (output valid, op, center_x, center_y, center_z, radius,
                  half_axis_0, half_axis_1, half_axis_2, input ready);
  modport sink   (input valid, op, center_x, center_y, center_z, radius,
                  half_axis_0, half_axis_1, half_axis_2, output ready);
endinterface

interface fct_out_if;
  logic       valid;
  logic       ready;
  logic       visible;
  logic [1:0] position;
  modport source (output valid, visible, position, input ready);
  modport sink   (input valid, visible, position, output ready);
endinterface

// ----- src/frustum_cull_test.sv -----
// Frustum cull test: one result word per accepted query, in query order.
// One query per cycle unless output stalls; all six planes run in parallel
// lanes through a 4-stage pipeline (multiply, sum, compare, reduce).
// A stall freezes every stage; a full output stage accepts if it is read.
// Synchronous active-low reset clears valid bits and all plane registers.
module frustum_cull_test #(
  parameter int FRAC_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fct_pkg::CFG_DATA_W-1:0] cfg_data,
  fct_in_if.sink                        in_ch,
  fct_out_if.source                     out_ch
);

  localparam int NP = fct_pkg::PLANE_COUNT;
  localparam int PW = fct_pkg::PROD_W;
  localparam int SW = fct_pkg::SUM_W;
  localparam int ONE_SH = fct_pkg::NORM_FRAC + FRAC_BITS;

  logic [fct_pkg::CFG_DATA_W-1:0] plane_r [NP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) plane_r[i] <= '0;
    end else if (cfg_we && (32'(cfg_index) < NP)) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // pipeline advance: whole pipe moves unless the output word is stuck
  logic [3:0] v_r;
  logic       adv;
  assign adv = !(v_r[3] && !out_ch.ready);
  assign in_ch.ready = adv;

  // stage 1: products
  logic signed [PW-1:0] pc_r [NP][3];   // center products
  logic signed [PW-1:0] ph_r [NP][3][3]; // axis k, component j
  logic signed [PW-1:0] d_r  [NP];
  logic [1:0]           op1_r;
  logic [14:0]          rad1_r;

  function automatic fct_pkg::s16_t f16(input logic [63:0] w, input int sh);
    return fct_pkg::s16_t'(w[sh +: 16]);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r  <= in_ch.op;
      rad1_r <= in_ch.radius;
      for (int p = 0; p < NP; p++) begin
        pc_r[p][0] <= f16(plane_r[p], 0)  * in_ch.center_x;
        pc_r[p][1] <= f16(plane_r[p], 16) * in_ch.center_y;
        pc_r[p][2] <= f16(plane_r[p], 32) * in_ch.center_z;
        d_r[p] <= PW'(f16(plane_r[p], 48)) <<< fct_pkg::NORM_FRAC;
        for (int j = 0; j < 3; j++) begin
          ph_r[p][0][j] <= f16(plane_r[p], 16*j) * fct_pkg::s16_t'(in_ch.half_axis_0[16*j +: 16]);
          ph_r[p][1][j] <= f16(plane_r[p], 16*j) * fct_pkg::s16_t'(in_ch.half_axis_1[16*j +: 16]);
          ph_r[p][2][j] <= f16(plane_r[p], 16*j) * fct_pkg::s16_t'(in_ch.half_axis_2[16*j +: 16]);
        end
      end
    end
  end

  // stage 2: distance and per-axis absolute projections
  logic signed [SW-1:0] dist2_r [NP];
  logic [SW-1:0]        pr2_r   [NP][3];
  logic [1:0]           op2_r;
  logic [14:0]          rad2_r;

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] s;
    if (adv) begin
      op2_r  <= op1_r;
      rad2_r <= rad1_r;
      for (int p = 0; p < NP; p++) begin
        dist2_r[p] <= SW'(pc_r[p][0]) + SW'(pc_r[p][1]) + SW'(pc_r[p][2]) + SW'(d_r[p]);
        for (int k = 0; k < 3; k++) begin
          s = SW'(ph_r[p][k][0]) + SW'(ph_r[p][k][1]) + SW'(ph_r[p][k][2]);
          pr2_r[p][k] <= s[SW-1] ? SW'(-s) : SW'(s);
        end
      end
    end
  end

  // stage 3: extents and per-plane tests
  logic [NP-1:0] cull3_r, span3_r, back3_r;
  logic [1:0]    op3_r;

  always_ff @(posedge clk) begin
    logic signed [SW+1:0] ext, dst, rad, one;
    if (adv) begin
      op3_r <= op2_r;
      for (int p = 0; p < NP; p++) begin
        ext = (SW+2)'(pr2_r[p][0]) + (SW+2)'(pr2_r[p][1]) + (SW+2)'(pr2_r[p][2]);
        dst = (SW+2)'(dist2_r[p]);
        rad = (SW+2)'({rad2_r, {fct_pkg::NORM_FRAC{1'b0}}});
        one = (SW+2)'(1) <<< ONE_SH;
        unique case (fct_pkg::op_t'(op2_r))
          fct_pkg::OP_POINT:  cull3_r[p] <= dst < 0;
          fct_pkg::OP_SPHERE: cull3_r[p] <= dst <= -rad;
          default:            cull3_r[p] <= dst <= -ext;
        endcase
        span3_r[p] <= dst <= ext;
        back3_r[p] <= dst + one < -ext;
      end
    end
  end

  // stage 4: reduce to output word
  logic       vis_r;
  logic [1:0] pos_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fct_pkg::op_t'(op3_r) == fct_pkg::OP_CLASS) begin
        vis_r <= 1'b0;
        pos_r <= (|back3_r) ? fct_pkg::POS_BACK :
                 (|span3_r) ? fct_pkg::POS_SPAN : fct_pkg::POS_FRONT;
      end else begin
        vis_r <= ~(|cull3_r);
        pos_r <= fct_pkg::POS_FRONT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_ch.valid};
    end
  end

  assign out_ch.valid    = v_r[3];
  assign out_ch.visible  = vis_r;
  assign out_ch.position = pos_r;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(vis_r) && $stable(pos_r)))
    else $error("result word changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input blocked without output stall");
  a_class_vis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.position != fct_pkg::POS_FRONT) |-> !out_ch.visible)
    else $error("visible set on classify result");
`endif

endmodule

// ----- tb/frustum_cull_test_tb.sv -----
// Testbench for the frustum cull test block: directed and random queries, checked in order.
`timescale 1ns / 100ps

module frustum_cull_test_tb;

  localparam int LATENCY   = 4;
  localparam int FRAC      = 4;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic       visible;
    logic [1:0] position;
  } cull_word_t;

  typedef struct {
    fct_pkg::op_t op;
    logic [15:0]  cx, cy, cz;
    logic [14:0]  radius;
    logic [47:0]  ha0, ha1, ha2;
  } query_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fct_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fct_in_if  in_ch();
  fct_out_if out_ch();

  frustum_cull_test #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  logic [63:0] planes [fct_pkg::PLANE_COUNT];
  cull_word_t  expected_words[$];
  int          errors = 0;
  int          cycle = 0;
  int          words_seen = 0;
  int          queries_sent = 0;
  int          op_count [4];
  bit          hold_off = 1'b0;
  bit          burst_mode = 1'b1;

  function automatic longint sx16(logic [63:0] w, int sh);
    logic signed [15:0] f;
    f = w[sh +: 16];
    return longint'(f);
  endfunction

  function automatic cull_word_t predict_cull(query_t q);
    cull_word_t r;
    longint a, b, c, d, dst, ext, s, rad, unit;
    bit culled, back, span;
    logic [47:0] axes [3];
    axes[0] = q.ha0; axes[1] = q.ha1; axes[2] = q.ha2;
    rad = longint'(q.radius) <<< fct_pkg::NORM_FRAC;
    unit = longint'(1) <<< (fct_pkg::NORM_FRAC + FRAC);
    culled = 0; back = 0; span = 0;
    for (int i = 0; i < fct_pkg::PLANE_COUNT; i++) begin
      a = sx16(planes[i], 0);
      b = sx16(planes[i], 16);
      c = sx16(planes[i], 32);
      d = sx16(planes[i], 48) <<< fct_pkg::NORM_FRAC;
      dst = a * sx16(q.cx, 0) + b * sx16(q.cy, 0) + c * sx16(q.cz, 0) + d;
      ext = 0;
      for (int k = 0; k < 3; k++) begin
        s = a * sx16(axes[k], 0) + b * sx16(axes[k], 16) + c * sx16(axes[k], 32);
        ext += (s < 0) ? -s : s;
      end
      case (q.op)
        fct_pkg::OP_POINT:  if (dst < 0) culled = 1;
        fct_pkg::OP_SPHERE: if (dst <= -rad) culled = 1;
        fct_pkg::OP_BOX:    if (dst <= -ext) culled = 1;
        default: begin
          if (dst <= ext) span = 1;
          if (dst + unit < -ext) back = 1;
        end
      endcase
    end
    if (q.op == fct_pkg::OP_CLASS) begin
      r.visible = 1'b0;
      r.position = back ? fct_pkg::POS_BACK : (span ? fct_pkg::POS_SPAN : fct_pkg::POS_FRONT);
    end else begin
      r.visible = !culled;
      r.position = fct_pkg::POS_FRONT;
    end
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.center_z = '0;
    in_ch.radius = '0;
    in_ch.half_axis_0 = '0;
    in_ch.half_axis_1 = '0;
    in_ch.half_axis_2 = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("frustum_cull_test_tb NOT OK");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    cull_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.visible = out_ch.visible;
      got.position = out_ch.position;
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: visible=%0d position=%0d",
               got.visible, got.position);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got.visible !== want.visible) begin
          $error("visible: expected %0d, actual %0d", want.visible, got.visible);
          errors++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, got.position);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else if (!burst_mode) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_query(query_t q);
    int gap;
    if (burst_mode && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= q.op;
    in_ch.center_x <= q.cx;
    in_ch.center_y <= q.cy;
    in_ch.center_z <= q.cz;
    in_ch.radius <= q.radius;
    in_ch.half_axis_0 <= q.ha0;
    in_ch.half_axis_1 <= q.ha1;
    in_ch.half_axis_2 <= q.ha2;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(predict_cull(q));
    queries_sent++;
    op_count[q.op]++;
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_plane(int idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx[fct_pkg::CFG_IDX_W-1:0];
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < fct_pkg::PLANE_COUNT) planes[idx] = value;
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand_axis(int span);
    logic [47:0] v;
    for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($urandom_range(0, 2 * span) - span);
    return v;
  endfunction

  function automatic query_t rand_query(int span);
    query_t q;
    q.op = fct_pkg::op_t'($urandom_range(0, 3));
    q.cx = 16'($urandom_range(0, 2 * span) - span);
    q.cy = 16'($urandom_range(0, 2 * span) - span);
    q.cz = 16'($urandom_range(0, 2 * span) - span);
    q.radius = 15'($urandom_range(0, span));
    q.ha0 = rand_axis(span / 4);
    q.ha1 = rand_axis(span / 4);
    q.ha2 = rand_axis(span / 4);
    return q;
  endfunction

  function automatic query_t raw_query();
    query_t q;
    q.op = fct_pkg::op_t'($urandom_range(0, 3));
    q.cx = 16'($urandom); q.cy = 16'($urandom); q.cz = 16'($urandom);
    q.radius = 15'($urandom);
    q.ha0 = 48'({$urandom, $urandom});
    q.ha1 = 48'({$urandom, $urandom});
    q.ha2 = 48'({$urandom, $urandom});
    return q;
  endfunction

  // axis-aligned box frustum: |x|,|y|,|z| <= lim (Q12.4 units)
  task automatic load_box_frustum(int lim);
    logic [15:0] one_n, neg_n, dd;
    one_n = 16'sd16383;  // just under 1.0 in Q2.14
    neg_n = -16'sd16384;
    dd = 16'(lim);
    write_plane(0, {dd, 16'd0, 16'd0, one_n});
    write_plane(1, {dd, 16'd0, 16'd0, neg_n});
    write_plane(2, {dd, 16'd0, neg_n, 16'd0});
    write_plane(3, {dd, 16'd0, one_n, 16'd0});
    write_plane(4, {dd, one_n, 16'd0, 16'd0});
    write_plane(5, {dd, neg_n, 16'd0, 16'd0});
  endtask

  task automatic test_reset_planes();
    query_t q;
    // all planes zero: points and spheres of nonzero radius touch, boxes are culled, classify spans
    for (int o = 0; o < 4; o++) begin
      q = raw_query();
      q.op = fct_pkg::op_t'(o);
      send_query(q);
    end
    go_idle();
  endtask

  task automatic test_directed();
    query_t q;
    logic [15:0] ext [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    load_box_frustum(1600);
    // field extremes on every op
    for (int o = 0; o < 4; o++)
      for (int e = 0; e < 4; e++) begin
        q.op = fct_pkg::op_t'(o);
        q.cx = ext[e]; q.cy = ext[(e + 1) % 4]; q.cz = ext[(e + 2) % 4];
        q.radius = (e == 1) ? 15'h7fff : (e == 2 ? 15'h0 : 15'h1234);
        q.ha0 = {3{ext[e]}};
        q.ha1 = {3{ext[(e + 3) % 4]}};
        q.ha2 = {ext[0], ext[1], ext[2]};
        send_query(q);
      end
    // exactly on a plane: point touches; sphere and box just past the face
    q = '{fct_pkg::OP_POINT, 16'd1600, 16'd0, 16'd0, 15'd0, '0, '0, '0};
    send_query(q);
    q.op = fct_pkg::OP_SPHERE;
    q.cx = 16'd1700; q.radius = 15'd100;
    send_query(q);
    q.op = fct_pkg::OP_BOX;
    q.ha0 = {16'd0, 16'd0, 16'd100};
    send_query(q);
    // classify: deep behind, spanning, fully in front
    q.op = fct_pkg::OP_CLASS;
    q.cx = 16'd3000; q.ha0 = {16'd0, 16'd0, 16'd10};
    send_query(q);
    q.cx = 16'd1600;
    send_query(q);
    q.cx = 16'd0;
    send_query(q);
    go_idle();
  endtask

  task automatic test_random_planes();
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < fct_pkg::PLANE_COUNT; i++)
        write_plane(i, (phase == 3) ? {64{1'b1}} :
                       (phase == 2) ? {16'h7fff, 16'h8000, 16'h7fff, 16'h8000} :
                       {$urandom, $urandom});
      write_plane(6 + phase % 2, {$urandom, $urandom});  // out-of-range index
      burst_mode = (phase != 1);
      for (int n = 0; n < 40; n++) send_query(raw_query());
      go_idle();
    end
    burst_mode = 1'b1;
  endtask

  task automatic test_random_queries();
    query_t q;
    for (int phase = 0; phase < 3; phase++) begin
      load_box_frustum($urandom_range(200, 4000));
      for (int n = 0; n < 80; n++) begin
        q = ($urandom_range(0, 9) == 0) ? raw_query() : rand_query(5000);
        send_query(q);
      end
      go_idle();
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 30; n++) send_query(rand_query(3000));
    join
    go_idle();
  endtask

  initial begin
    foreach (planes[i]) planes[i] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_planes();
    test_directed();
    test_random_planes();
    test_random_queries();
    test_backpressure();
    $display("sent %0d queries (point %0d, sphere %0d, box %0d, classify %0d), %0d checked",
             queries_sent, op_count[0], op_count[1], op_count[2], op_count[3], words_seen);
    $display("plane sets: reset, axis box, extremes, all ones, random; with a long output stall");
    if (errors == 0) begin
      $display("frustum_cull_test_tb OK");
    end else begin
      $display("frustum_cull_test_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/fct_pkg.sv
src/fct_if.sv
src/frustum_cull_test.sv
tb/frustum_cull_test_tb.sv
